// File: design/capability_table_engine_core_assert.svh
// Assertion macros for the capability table engine core.
// Depends on nothing; included by the files that carry assertions.
`ifndef CAPABILITY_TABLE_ENGINE_CORE_ASSERT_SVH
`define CAPABILITY_TABLE_ENGINE_CORE_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define CTE_ASSERT_SAME(label, clk_i, rst_ni, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error("capability table engine check failed");

// Check that a condition holds in the cycle after its trigger.
`define CTE_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error("capability table engine check failed");

`endif

// File: design/cte_pkg.sv
// Shared types and constants of the capability table engine.
// Depends on nothing; used by capability_table_engine_core and its testbench.
package cte_pkg;

    localparam int NUM_TASKS_DEF   = 8;
    localparam int NUM_SLOTS_DEF   = 64;
    localparam int OBJECT_BITS_DEF = 16;
    localparam int TYPE_BITS_DEF   = 4;

    localparam int RIGHTS_W = 3;
    localparam int BADGE_W  = 32;

    localparam logic [3:0] TASK_COUNT_RST = 4'd8;

    typedef enum logic [2:0] {
        OP_LOOKUP  = 3'd0,
        OP_DELETE  = 3'd1,
        OP_DERIVE  = 3'd2,
        OP_MINT    = 3'd3,
        OP_GRANT   = 3'd4,
        OP_REVOKE  = 3'd5,
        OP_INSTALL = 3'd6
    } opcode_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } fsm_state_t;

endpackage

// File: design/capability_table_engine_core.sv
// Capability table engine: per-task capability tables in one single-port-write memory.
// Depends on cte_pkg and capability_table_engine_core_assert.svh.
//
// Usage: after reset the block sweeps the whole table to empty, one entry per
// cycle, and keeps busy high until that pass is done. A command transfers on a
// rising edge with start high and busy low; every command yields exactly one
// result, shown on ok, cap_type, object_id, cap_rights and cap_badge for the
// single cycle in which done is high. The receiver cannot stall: sample the
// result in that cycle or lose it. Lookup, delete, derive, mint, grant, install
// and a failing revoke hold busy through the execute state after the transfer
// (the table read) and strobe done in the cycle after it, in which busy is low
// and the next command may transfer. A successful revoke walks the first
// min(task_count, NUM_TASKS) task tables through the one read port and the one
// write port of the table memory, and holds busy until that sweep is done.
// task_count is written through cfg_write / cfg_data at any time, but only takes
// defined effect while the block is idle.
module capability_table_engine_core #(
    parameter int NUM_TASKS   = cte_pkg::NUM_TASKS_DEF,
    parameter int NUM_SLOTS   = cte_pkg::NUM_SLOTS_DEF,
    parameter int OBJECT_BITS = cte_pkg::OBJECT_BITS_DEF,
    parameter int TYPE_BITS   = cte_pkg::TYPE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [3:0]  cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [2:0]  from_task,
    input  logic [2:0]  to_task,
    input  logic [7:0]  from_slot,
    input  logic [7:0]  to_slot,
    input  logic [2:0]  req_rights,
    input  logic [31:0] new_badge,
    input  logic [3:0]  new_type,
    input  logic [15:0] new_object,
    output logic        done,
    output logic        ok,
    output logic [3:0]  cap_type,
    output logic [15:0] object_id,
    output logic [2:0]  cap_rights,
    output logic [31:0] cap_badge
);

    `include "capability_table_engine_core_assert.svh"

    localparam int ENTRY_COUNT = NUM_TASKS * NUM_SLOTS;
    localparam int AW          = $clog2(ENTRY_COUNT);
    localparam int CW          = $clog2(ENTRY_COUNT + 1);
    localparam int LIM_W       = 9;
    localparam int NT_W        = 7;
    localparam logic [LIM_W-1:0] TASK_LIM = LIM_W'(NUM_TASKS);
    localparam logic [LIM_W-1:0] SLOT_LIM = LIM_W'(NUM_SLOTS);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(ENTRY_COUNT - 1);

    typedef struct packed {
        logic [TYPE_BITS-1:0]          ctype;
        logic [OBJECT_BITS-1:0]        obj;
        logic [cte_pkg::RIGHTS_W-1:0]  rights;
        logic [cte_pkg::BADGE_W-1:0]   badge;
    } entry_t;

    // Table storage: one write and one registered read per cycle.
    entry_t cap_mem [0:ENTRY_COUNT-1];

    cte_pkg::fsm_state_t state_reg, state_next;

    logic [3:0]    task_count_reg;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [AW-1:0] chk_addr_reg;
    logic [CW-1:0] limit_reg, limit_next;
    logic [OBJECT_BITS-1:0] target_reg;

    // Command captured at transfer.
    cte_pkg::opcode_t              op_reg;
    logic                          src_ok_reg, dst_ok_reg;
    logic [AW-1:0]                 src_addr_reg, dst_addr_reg;
    logic [cte_pkg::RIGHTS_W-1:0]  rights_reg;
    logic [cte_pkg::BADGE_W-1:0]   badge_reg;
    logic [TYPE_BITS-1:0]          type_reg;
    logic [OBJECT_BITS-1:0]        obj_reg;

    entry_t rd_data_reg;

    // Result register.
    logic        done_reg, done_next;
    logic        ok_reg, ok_next;
    logic [3:0]  res_type_reg, res_type_next;
    logic [15:0] res_obj_reg, res_obj_next;
    logic [2:0]  res_rights_reg, res_rights_next;
    logic [31:0] res_badge_reg, res_badge_next;

    logic          accept;
    logic [2:0]    to_task_sel;
    logic          src_ok_in, dst_ok_in;
    logic [AW-1:0] src_addr_in, dst_addr_in;
    logic          src_full, escalate, lookup_ok, copy_ok, revoke_go;
    logic          sweep_issue, sweep_hit;
    logic [NT_W-1:0] scan_tasks;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    logic          res_zero, sweep_wr;

    assign busy   = (state_reg != cte_pkg::ST_IDLE);
    assign accept = start && !busy;

    // Address decode of the incoming command; grant is the only cross-task copy.
    always_comb
    begin
        to_task_sel = (cte_pkg::opcode_t'(opcode) == cte_pkg::OP_GRANT) ? to_task : from_task;
        src_ok_in   = (LIM_W'(from_task) < TASK_LIM) && (LIM_W'(from_slot) < SLOT_LIM);
        dst_ok_in   = (LIM_W'(to_task_sel) < TASK_LIM) && (LIM_W'(to_slot) < SLOT_LIM);
        src_addr_in = AW'(int'(from_task) * NUM_SLOTS + int'(from_slot));
        dst_addr_in = AW'(int'(to_task_sel) * NUM_SLOTS + int'(to_slot));
    end

    // Checks on the source entry read back in the execute cycle, and sweep status.
    always_comb
    begin
        src_full    = (rd_data_reg.ctype != '0);
        escalate    = ((rights_reg & ~rd_data_reg.rights) != '0);
        lookup_ok   = src_ok_reg && src_full;
        copy_ok     = src_ok_reg && dst_ok_reg && src_full && !escalate;
        revoke_go   = src_ok_reg && src_full && (rd_data_reg.obj != '0);
        scan_tasks  = (NT_W'(task_count_reg) < NT_W'(NUM_TASKS)) ?
                      NT_W'(task_count_reg) : NT_W'(NUM_TASKS);
        limit_next  = CW'(int'(scan_tasks) * NUM_SLOTS);
        sweep_issue = (cnt_reg < limit_reg);
        sweep_hit   = chk_valid_reg && (rd_data_reg.obj == target_reg) &&
                      (chk_addr_reg != src_addr_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cte_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ADDR)
                    state_next = cte_pkg::ST_IDLE;
            end
            cte_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = cte_pkg::ST_EXEC;
            end
            cte_pkg::ST_EXEC:
            begin
                if (op_reg == cte_pkg::OP_REVOKE && revoke_go)
                    state_next = cte_pkg::ST_SWEEP;
                else
                    state_next = cte_pkg::ST_IDLE;
            end
            cte_pkg::ST_SWEEP:
            begin
                if (!sweep_issue)
                    state_next = cte_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cte_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: memory ports, counters and the next result.
    always_comb
    begin
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        clr_cnt_next    = clr_cnt_reg;
        cnt_next        = cnt_reg;
        chk_valid_next  = 1'b0;
        done_next       = 1'b0;
        ok_next         = 1'b0;
        res_type_next   = '0;
        res_obj_next    = '0;
        res_rights_next = '0;
        res_badge_next  = '0;
        unique case (state_reg)
            cte_pkg::ST_CLEAR:
            begin
                // Zero one entry per cycle.
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            cte_pkg::ST_IDLE:
            begin
                // Fetch the source entry at the transfer edge.
                rd_en   = accept;
                rd_addr = src_ok_in ? src_addr_in : '0;
            end
            cte_pkg::ST_EXEC:
            begin
                done_next = 1'b1;
                cnt_next  = '0;
                unique case (op_reg) inside
                    cte_pkg::OP_LOOKUP:
                    begin
                        ok_next = lookup_ok;
                        if (lookup_ok)
                        begin
                            res_type_next   = 4'(rd_data_reg.ctype);
                            res_obj_next    = 16'(rd_data_reg.obj);
                            res_rights_next = rd_data_reg.rights;
                            res_badge_next  = rd_data_reg.badge;
                        end
                    end
                    cte_pkg::OP_DELETE:
                    begin
                        // Drop type and object, keep rights and badge.
                        ok_next       = src_ok_reg;
                        wr_en         = src_ok_reg;
                        wr_addr       = src_addr_reg;
                        wr_data       = rd_data_reg;
                        wr_data.ctype = '0;
                        wr_data.obj   = '0;
                    end
                    cte_pkg::OP_DERIVE, cte_pkg::OP_MINT, cte_pkg::OP_GRANT:
                    begin
                        ok_next        = copy_ok;
                        wr_en          = copy_ok;
                        wr_addr        = dst_addr_reg;
                        wr_data.ctype  = rd_data_reg.ctype;
                        wr_data.obj    = rd_data_reg.obj;
                        wr_data.rights = rights_reg;
                        wr_data.badge  = (op_reg == cte_pkg::OP_DERIVE) ?
                                         rd_data_reg.badge : badge_reg;
                    end
                    cte_pkg::OP_REVOKE:
                    begin
                        // On success the result comes at the end of the sweep.
                        done_next = !revoke_go;
                    end
                    cte_pkg::OP_INSTALL:
                    begin
                        ok_next        = src_ok_reg;
                        wr_en          = src_ok_reg;
                        wr_addr        = src_addr_reg;
                        wr_data.ctype  = type_reg;
                        wr_data.obj    = (type_reg != '0) ? obj_reg : '0;
                        wr_data.rights = rights_reg;
                        wr_data.badge  = badge_reg;
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            cte_pkg::ST_SWEEP:
            begin
                // Read entry cnt while the entry read last cycle is checked and cleared.
                rd_en          = sweep_issue;
                rd_addr        = cnt_reg[AW-1:0];
                chk_valid_next = sweep_issue;
                if (sweep_issue)
                    cnt_next = cnt_reg + CW'(1);
                wr_en         = sweep_hit;
                wr_addr       = chk_addr_reg;
                wr_data       = rd_data_reg;
                wr_data.ctype = '0;
                wr_data.obj   = '0;
                if (!sweep_issue)
                begin
                    done_next = 1'b1;
                    ok_next   = 1'b1;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cte_pkg::ST_CLEAR;
            clr_cnt_reg    <= '0;
            cnt_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            done_reg       <= 1'b0;
            task_count_reg <= cte_pkg::TASK_COUNT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cnt_reg       <= cnt_next;
            chk_valid_reg <= chk_valid_next;
            done_reg      <= done_next;
            if (cfg_write)
                task_count_reg <= cfg_data;
        end
    end

    // Payload: command capture, sweep bookkeeping and result fields.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= cte_pkg::opcode_t'(opcode);
            src_ok_reg   <= src_ok_in;
            dst_ok_reg   <= dst_ok_in;
            src_addr_reg <= src_addr_in;
            dst_addr_reg <= dst_addr_in;
            rights_reg   <= req_rights;
            badge_reg    <= new_badge;
            type_reg     <= TYPE_BITS'(new_type);
            obj_reg      <= OBJECT_BITS'(new_object);
        end
        if (state_reg == cte_pkg::ST_EXEC)
        begin
            target_reg <= rd_data_reg.obj;
            limit_reg  <= limit_next;
        end
        chk_addr_reg   <= cnt_reg[AW-1:0];
        ok_reg         <= ok_next;
        res_type_reg   <= res_type_next;
        res_obj_reg    <= res_obj_next;
        res_rights_reg <= res_rights_next;
        res_badge_reg  <= res_badge_next;
    end

    // Table memory.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            cap_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= cap_mem[rd_addr];
    end

    assign done       = done_reg;
    assign ok         = ok_reg;
    assign cap_type   = res_type_reg;
    assign object_id  = res_obj_reg;
    assign cap_rights = res_rights_reg;
    assign cap_badge  = res_badge_reg;

    assign res_zero = (res_type_reg == '0) && (res_obj_reg == '0) &&
                      (res_rights_reg == '0) && (res_badge_reg == '0);
    assign sweep_wr = (state_reg == cte_pkg::ST_SWEEP) && wr_en;

    `CTE_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, accept, state_reg == cte_pkg::ST_EXEC)
    `CTE_ASSERT_SAME(a_done_when_idle, clk, rst_n, done_reg, state_reg == cte_pkg::ST_IDLE)
    `CTE_ASSERT_SAME(a_fail_zero_fields, clk, rst_n, done_reg && !ok_reg, res_zero)
    `CTE_ASSERT_SAME(a_sweep_keeps_source, clk, rst_n, sweep_wr, wr_addr != src_addr_reg)

endmodule

// File: test/tb_capability_table_engine_core.sv
`timescale 1ns / 100ps
// Testbench for capability_table_engine_core: directed and random command streams,
// each result checked field by field against a behavioral model of the task tables.
// Depends on cte_pkg and the capability_table_engine_core RTL.
module tb_capability_table_engine_core;

    localparam int TASKS = cte_pkg::NUM_TASKS_DEF;
    localparam int SLOTS = cte_pkg::NUM_SLOTS_DEF;
    localparam int ENTRIES = TASKS * SLOTS;

    // Opcode 7 has no member in opcode_t; the block must answer it with ok low.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // Longest quiet stretch is the clearing pass or a full revoke sweep plus a
    // sender gap; allow several times that.
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  from_task;
        logic [2:0]  to_task;
        logic [7:0]  from_slot;
        logic [7:0]  to_slot;
        logic [2:0]  req_rights;
        logic [31:0] new_badge;
        logic [3:0]  new_type;
        logic [15:0] new_object;
    } table_cmd_t;

    typedef struct packed {
        logic        ok;
        logic [3:0]  cap_type;
        logic [15:0] object_id;
        logic [2:0]  cap_rights;
        logic [31:0] cap_badge;
    } cap_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [3:0]  cfg_data;
    logic        start;
    logic        busy;
    logic [2:0]  opcode;
    logic [2:0]  from_task;
    logic [2:0]  to_task;
    logic [7:0]  from_slot;
    logic [7:0]  to_slot;
    logic [2:0]  req_rights;
    logic [31:0] new_badge;
    logic [3:0]  new_type;
    logic [15:0] new_object;
    logic        done;
    logic        ok;
    logic [3:0]  cap_type;
    logic [15:0] object_id;
    logic [2:0]  cap_rights;
    logic [31:0] cap_badge;

    // Model copy of the capability tables, indexed by task * SLOTS + slot.
    logic [3:0]  tbl_type   [ENTRIES];
    logic [15:0] tbl_object [ENTRIES];
    logic [2:0]  tbl_rights [ENTRIES];
    logic [31:0] tbl_badge  [ENTRIES];
    logic [3:0]  sweep_tasks;

    cap_result_t pending_results[$];
    int          mismatches = 0;
    int          stall_cycles = 0;
    int          sender_idle_pct = 0;

    capability_table_engine_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .start      (start),
        .busy       (busy),
        .opcode     (opcode),
        .from_task  (from_task),
        .to_task    (to_task),
        .from_slot  (from_slot),
        .to_slot    (to_slot),
        .req_rights (req_rights),
        .new_badge  (new_badge),
        .new_type   (new_type),
        .new_object (new_object),
        .done       (done),
        .ok         (ok),
        .cap_type   (cap_type),
        .object_id  (object_id),
        .cap_rights (cap_rights),
        .cap_badge  (cap_badge)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------

    function automatic bit addr_valid(logic [2:0] task_id, logic [7:0] slot);
        return (int'(task_id) < TASKS) && (int'(slot) < SLOTS);
    endfunction

    function automatic int entry_of(logic [2:0] task_id, logic [7:0] slot);
        return int'(task_id) * SLOTS + int'(slot);
    endfunction

    // Copy a capability with reduced rights; refuse an empty source or any
    // requested right that the source does not hold.
    function automatic bit copy_capability(int from, int to, logic [2:0] rights,
                                           bit keep_badge, logic [31:0] badge);
        logic [31:0] badge_out;
        if (tbl_type[from] == '0)
            return 1'b0;
        if ((rights & ~tbl_rights[from]) != '0)
            return 1'b0;
        badge_out = keep_badge ? tbl_badge[from] : badge;
        tbl_type[to]   = tbl_type[from];
        tbl_object[to] = tbl_object[from];
        tbl_rights[to] = rights;
        tbl_badge[to]  = badge_out;
        return 1'b1;
    endfunction

    // Apply one command to the model tables and return the result it must give.
    function automatic cap_result_t predict_table_op(table_cmd_t c);
        cap_result_t r;
        int          src;
        int          swept;
        logic [15:0] target;
        r = '0;
        src = entry_of(c.from_task, c.from_slot);
        case (c.opcode) inside
            cte_pkg::OP_LOOKUP:
            begin
                if (addr_valid(c.from_task, c.from_slot))
                begin
                    if (tbl_type[src] != '0)
                    begin
                        r.ok         = 1'b1;
                        r.cap_type   = tbl_type[src];
                        r.object_id  = tbl_object[src];
                        r.cap_rights = tbl_rights[src];
                        r.cap_badge  = tbl_badge[src];
                    end
                end
            end
            cte_pkg::OP_DELETE:
            begin
                // Rights and badge stay behind in the emptied slot.
                if (addr_valid(c.from_task, c.from_slot))
                begin
                    tbl_type[src]   = '0;
                    tbl_object[src] = '0;
                    r.ok = 1'b1;
                end
            end
            cte_pkg::OP_DERIVE, cte_pkg::OP_MINT:
            begin
                if (addr_valid(c.from_task, c.from_slot) && addr_valid(c.from_task, c.to_slot))
                    r.ok = copy_capability(src, entry_of(c.from_task, c.to_slot),
                                           c.req_rights,
                                           c.opcode == cte_pkg::OP_DERIVE,
                                           c.new_badge);
            end
            cte_pkg::OP_GRANT:
            begin
                if (addr_valid(c.from_task, c.from_slot) && addr_valid(c.to_task, c.to_slot))
                    r.ok = copy_capability(src, entry_of(c.to_task, c.to_slot),
                                           c.req_rights, 1'b0, c.new_badge);
            end
            cte_pkg::OP_REVOKE:
            begin
                if (addr_valid(c.from_task, c.from_slot))
                begin
                    target = tbl_object[src];
                    if (tbl_type[src] != '0 && target != '0)
                    begin
                        swept = (int'(sweep_tasks) < TASKS) ? int'(sweep_tasks) : TASKS;
                        for (int e = 0; e < swept * SLOTS; e++)
                        begin
                            if (e != src && tbl_object[e] == target)
                            begin
                                tbl_type[e]   = '0;
                                tbl_object[e] = '0;
                            end
                        end
                        r.ok = 1'b1;
                    end
                end
            end
            cte_pkg::OP_INSTALL:
            begin
                if (addr_valid(c.from_task, c.from_slot))
                begin
                    tbl_type[src]   = c.new_type;
                    tbl_object[src] = (c.new_type != '0) ? c.new_object : '0;
                    tbl_rights[src] = c.req_rights;
                    tbl_badge[src]  = c.new_badge;
                    r.ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic table_cmd_t table_cmd(logic [2:0] op, logic [2:0] st, logic [7:0] ss,
                                             logic [2:0] dt, logic [7:0] ds,
                                             logic [2:0] rights, logic [31:0] badge,
                                             logic [3:0] ntype, logic [15:0] nobj);
        table_cmd_t c;
        c.opcode     = op;
        c.from_task  = st;
        c.from_slot  = ss;
        c.to_task    = dt;
        c.to_slot    = ds;
        c.req_rights = rights;
        c.new_badge  = badge;
        c.new_type   = ntype;
        c.new_object = nobj;
        return c;
    endfunction

    // Mostly a handful of low slots so the tables fill up; some valid high
    // slots and some out of range.
    function automatic logic [7:0] pick_slot();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return 8'($urandom_range(7));
        else if (roll < 90)
            return 8'($urandom_range(SLOTS - 1, 8));
        return 8'($urandom_range(255, SLOTS));
    endfunction

    // A small object pool makes revokes hit several copies.
    function automatic logic [15:0] pick_object();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 16'($urandom_range(6, 1));
        else if (roll < 80)
            return '0;
        return 16'($urandom_range(65535));
    endfunction

    function automatic table_cmd_t random_cmd();
        table_cmd_t c;
        int         roll;
        roll = $urandom_range(99);
        if (roll < 22)
            c.opcode = cte_pkg::OP_INSTALL;
        else if (roll < 42)
            c.opcode = cte_pkg::OP_LOOKUP;
        else if (roll < 54)
            c.opcode = cte_pkg::OP_DERIVE;
        else if (roll < 64)
            c.opcode = cte_pkg::OP_MINT;
        else if (roll < 76)
            c.opcode = cte_pkg::OP_GRANT;
        else if (roll < 86)
            c.opcode = cte_pkg::OP_DELETE;
        else if (roll < 97)
            c.opcode = cte_pkg::OP_REVOKE;
        else
            c.opcode = OP_UNUSED;
        c.from_task  = 3'($urandom_range(7));
        c.to_task    = 3'($urandom_range(7));
        c.from_slot  = pick_slot();
        c.to_slot    = pick_slot();
        c.req_rights = 3'($urandom_range(7));
        c.new_badge  = $urandom;
        c.new_type   = ($urandom_range(99) < 85) ? 4'($urandom_range(15, 1)) : '0;
        c.new_object = pick_object();
        // Most copies ask for a subset of the source rights so they succeed.
        if ((c.opcode == cte_pkg::OP_DERIVE || c.opcode == cte_pkg::OP_MINT ||
             c.opcode == cte_pkg::OP_GRANT)
            && addr_valid(c.from_task, c.from_slot) && $urandom_range(99) < 70)
            c.req_rights = tbl_rights[entry_of(c.from_task, c.from_slot)] & 3'($urandom);
        return c;
    endfunction

    // Drive one command and hold it until it transfers. Start stays high on
    // return so a following command can go out back to back.
    task automatic send_cmd(input table_cmd_t c);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        opcode     <= c.opcode;
        from_task  <= c.from_task;
        to_task    <= c.to_task;
        from_slot  <= c.from_slot;
        to_slot    <= c.to_slot;
        req_rights <= c.req_rights;
        new_badge  <= c.new_badge;
        new_type   <= c.new_type;
        new_object <= c.new_object;
        // busy read here is its value before the edge, as the block saw it.
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_table_op(c));
    endtask

    // Drop start and wait until every outstanding result is back and the
    // block is idle.
    task automatic wait_until_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_results.size() != 0 || busy);
    endtask

    task automatic write_task_count(input logic [3:0] value);
        wait_until_drained();
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write   <= 1'b0;
        sweep_tasks = value;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Cleared table, install at the field extremes, install of an empty type.
    task automatic test_install_lookup();
        send_cmd(table_cmd(cte_pkg::OP_LOOKUP, 3'd0, 8'd0, 3'd0, 8'd0, 3'd0, '0, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_INSTALL, 3'd0, 8'd0, 3'd0, 8'd0, 3'd7,
                           32'hFFFF_FFFF, 4'hF, 16'hFFFF));
        send_cmd(table_cmd(cte_pkg::OP_INSTALL, 3'd7, 8'd63, 3'd0, 8'd0, 3'd0, '0,
                           4'd1, 16'd1));
        send_cmd(table_cmd(cte_pkg::OP_LOOKUP, 3'd0, 8'd0, 3'd0, 8'd0, 3'd0, '0, '0, '0));
        // Type zero stores an empty entry; the object id must not stick.
        send_cmd(table_cmd(cte_pkg::OP_INSTALL, 3'd3, 8'd4, 3'd0, 8'd0, 3'd5,
                           32'h1357_9BDF, 4'd0, 16'h1234));
        send_cmd(table_cmd(cte_pkg::OP_LOOKUP, 3'd3, 8'd4, 3'd0, 8'd0, 3'd0, '0, '0, '0));
    endtask

    // Derive keeps the badge, mint and grant replace it; escalation, empty
    // source and a bad slot all fail.
    task automatic test_copy_rights();
        send_cmd(table_cmd(cte_pkg::OP_DERIVE, 3'd0, 8'd0, 3'd0, 8'd1, 3'd3,
                           32'hDEAD_BEEF, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_LOOKUP, 3'd0, 8'd1, 3'd0, 8'd0, 3'd0, '0, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_MINT, 3'd0, 8'd0, 3'd0, 8'd2, 3'd4,
                           32'h1234_5678, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_DERIVE, 3'd7, 8'd63, 3'd0, 8'd62, 3'd1, '0, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_GRANT, 3'd0, 8'd1, 3'd5, 8'd10, 3'd2,
                           32'hCAFE_F00D, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_LOOKUP, 3'd5, 8'd10, 3'd0, 8'd0, 3'd0, '0, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_GRANT, 3'd0, 8'd0, 3'd6, 8'd64, 3'd1, '0, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_MINT, 3'd2, 8'd9, 3'd0, 8'd3, 3'd0, 32'h1, '0, '0));
    endtask

    // Delete empties a slot, succeeds on an empty slot, fails out of range.
    task automatic test_delete();
        send_cmd(table_cmd(cte_pkg::OP_DELETE, 3'd0, 8'd2, 3'd0, 8'd0, 3'd0, '0, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_LOOKUP, 3'd0, 8'd2, 3'd0, 8'd0, 3'd0, '0, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_DELETE, 3'd0, 8'd2, 3'd0, 8'd0, 3'd0, '0, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_DELETE, 3'd1, 8'd255, 3'd0, 8'd0, 3'd0, '0, '0, '0));
    endtask

    // Revoke keeps its source and clears its copies in every swept task; a source
    // with object zero or an empty source fails.
    task automatic test_revoke();
        send_cmd(table_cmd(cte_pkg::OP_INSTALL, 3'd4, 8'd5, 3'd0, 8'd0, 3'd7, 32'h1,
                           4'd2, 16'd0));
        send_cmd(table_cmd(cte_pkg::OP_REVOKE, 3'd4, 8'd5, 3'd0, 8'd0, 3'd0, '0, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_REVOKE, 3'd0, 8'd0, 3'd0, 8'd0, 3'd0, '0, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_LOOKUP, 3'd0, 8'd0, 3'd0, 8'd0, 3'd0, '0, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_LOOKUP, 3'd5, 8'd10, 3'd0, 8'd0, 3'd0, '0, '0, '0));
        send_cmd(table_cmd(cte_pkg::OP_REVOKE, 3'd2, 8'd9, 3'd0, 8'd0, 3'd0, '0, '0, '0));
    endtask

    task automatic test_unused_opcode();
        send_cmd(table_cmd(OP_UNUSED, 3'd0, 8'd0, 3'd1, 8'd1, 3'd7,
                           32'hFFFF_FFFF, 4'hF, 16'hFFFF));
    endtask

    // Random traffic under one sweep width and one sender idle rate.
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input logic [3:0] tasks_swept);
        write_task_count(tasks_swept);
        sender_idle_pct = idle_pct;
        repeat (count)
            send_cmd(random_cmd());
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
        mismatches++;
    endtask

    // Each result stands for one cycle only; take it at the edge that ends it.
    always @(posedge clk)
    begin
        cap_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no command outstanding", '0, 32'(ok));
            else
            begin
                want = pending_results.pop_front();
                if (ok !== want.ok)
                    report_mismatch("ok", 32'(want.ok), 32'(ok));
                if (cap_type !== want.cap_type)
                    report_mismatch("cap_type", 32'(want.cap_type), 32'(cap_type));
                if (object_id !== want.object_id)
                    report_mismatch("object_id", 32'(want.object_id), 32'(object_id));
                if (cap_rights !== want.cap_rights)
                    report_mismatch("cap_rights", 32'(want.cap_rights), 32'(cap_rights));
                if (cap_badge !== want.cap_badge)
                    report_mismatch("cap_badge", want.cap_badge, cap_badge);
            end
        end
    end

    // Watchdog: count cycles without a command transfer or a result.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        for (int e = 0; e < ENTRIES; e++)
        begin
            tbl_type[e]   = '0;
            tbl_object[e] = '0;
            tbl_rights[e] = '0;
            tbl_badge[e]  = '0;
        end
        sweep_tasks = cte_pkg::TASK_COUNT_RST;

        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_data   <= '0;
        start      <= 1'b0;
        opcode     <= cte_pkg::OP_LOOKUP;
        from_task  <= '0;
        to_task    <= '0;
        from_slot  <= '0;
        to_slot    <= '0;
        req_rights <= '0;
        new_badge  <= '0;
        new_type   <= '0;
        new_object <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The clearing pass holds busy; the first transfer waits it out.
        test_install_lookup();
        test_copy_rights();
        test_delete();
        test_revoke();
        test_unused_opcode();

        // Sender idles 32%, then 66%, then never; sweep width moves across
        // both extremes.
        test_random_traffic(267, 32, 4'd8);
        test_random_traffic(267, 32, 4'd1);
        test_random_traffic(267, 66, 4'd4);
        test_random_traffic(267, 66, 4'd8);
        test_random_traffic(266, 0, 4'd2);
        test_random_traffic(266, 0, 4'd7);

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/cte_pkg.sv
design/capability_table_engine_core.sv
test/tb_capability_table_engine_core.sv
